// ----- src/pcpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Path corridor projector package
// Shared beat types, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package pcpp_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_BACK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] HALF_WIDTH_RST    = 12'd282;
    localparam logic [CFG_W-1:0] CAMERA_BACK_RST   = 12'd51;
    localparam logic [CFG_W-1:0] CAMERA_HEIGHT_RST = 12'd256;
    localparam logic [CFG_W-1:0] PIXEL_SCALE_RST   = 12'd200;
    localparam logic [CFG_W-1:0] CENTER_X_RST      = 12'd280;
    localparam logic [CFG_W-1:0] CENTER_Y_RST      = 12'd210;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic               path_start;
        logic               path_end;
    } in_t;

    typedef struct packed {
        logic               side;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind_camera;
        logic               pair_last;
        logic               path_last;
    } out_t;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SQ   = 8'b0000_0010,
        ST_SQRT = 8'b0000_0100,
        ST_DIV  = 8'b0000_1000,
        ST_EDGE = 8'b0001_0000,
        ST_MUL  = 8'b0010_0000,
        ST_LOAD = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    // Destination of the divider result.
    typedef enum logic [1:0] {
        DT_OX = 2'd0,
        DT_OY = 2'd1,
        DT_SX = 2'd2,
        DT_SY = 2'd3
    } div_tgt_t;

endpackage

// ----- src/path_corridor_perspective_projector_core.sv -----
// ----------------------------------------------------------------------------
// Path corridor perspective projector
// Offsets each path point by half the car width and projects both edges.
// ----------------------------------------------------------------------------
// One point is in work at a time; a general point runs the bit-pair square
// root and the bit-serial divider (one quotient bit per cycle, used up to six
// times per point), while a path start or a repeated point skips the root and
// the offset divides. An output stall holds the sequencer. Reset (rst_n low,
// asynchronous) clears the sequencer, the previous point and loads the
// register defaults.
module path_corridor_perspective_projector_core #(
    parameter int FRAC_BITS = pcpp_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  pcpp_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output pcpp_pkg::out_t                     out_data,
    input  logic                               cfg_we,
    input  logic [pcpp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcpp_pkg::CFG_W-1:0]         cfg_data
);
    import pcpp_pkg::*;

    // Segment length has 17 integer-side bits plus FRAC_BITS.
    localparam int LW  = 17 + FRAC_BITS;
    // Square root runs one result bit (two radicand bits) per cycle.
    localparam int SI  = LW;
    localparam int SRW = 2 * SI;
    localparam int RW  = LW + 2;
    // Divider numerator covers the scaled offset product and the pixel sums.
    localparam int NW  = 28 + FRAC_BITS;
    localparam int DW  = LW;
    localparam int CW  = $clog2(NW + 1);

    // Configuration registers.
    logic [CFG_W-1:0] half_width_reg, camera_back_reg, camera_height_reg;
    logic [CFG_W-1:0] pixel_scale_reg, center_x_reg, center_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg    <= HALF_WIDTH_RST;
            camera_back_reg   <= CAMERA_BACK_RST;
            camera_height_reg <= CAMERA_HEIGHT_RST;
            pixel_scale_reg   <= PIXEL_SCALE_RST;
            center_x_reg      <= CENTER_X_RST;
            center_y_reg      <= CENTER_Y_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_WIDTH:    half_width_reg    <= cfg_data;
                REG_CAMERA_BACK:   camera_back_reg   <= cfg_data;
                REG_CAMERA_HEIGHT: camera_height_reg <= cfg_data;
                REG_PIXEL_SCALE:   pixel_scale_reg   <= cfg_data;
                REG_CENTER_X:      center_x_reg      <= cfg_data;
                REG_CENTER_Y:      center_y_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    logic signed [15:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic signed [15:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic               last_reg, last_next;
    logic signed [16:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [SRW-1:0]     rad_reg, rad_next;
    logic [LW-1:0]      root_reg, root_next;
    logic [RW-1:0]      srem_reg, srem_next;
    logic [NW-1:0]      num_reg, num_next;
    logic [DW-1:0]      drem_reg, drem_next, den_reg, den_next;
    logic               neg_reg, neg_next;
    div_tgt_t           tgt_reg, tgt_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [12:0] ox_reg, ox_next, oy_reg, oy_next;
    logic               side_reg, side_next;
    logic signed [17:0] ex_reg, ex_next, dist_reg, dist_next;
    logic signed [31:0] p1_reg, p1_next, p2_reg, p2_next;
    logic signed [15:0] sx_reg, sx_next;
    logic               behind_reg, behind_next;
    out_t               out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    // Combinational helpers.
    logic [15:0]        dx_mag, dy_mag;
    logic [32:0]        sq_sum;
    logic [RW-1:0]      s_rem2, s_trial, s_diff;
    logic               s_ge;
    logic [DW:0]        d_t, d_diff;
    logic               d_ge;
    logic [27:0]        off_prod_y, off_prod_x;
    logic signed [12:0] q13;
    logic signed [17:0] ex_w, ey_w, dist_w;
    logic signed [17:0] mul_a;
    logic signed [12:0] mul_b, mul_c;
    logic signed [30:0] prod1, prod2;
    logic signed [31:0] pix_sum;
    logic [31:0]        pix_mag;
    logic signed [15:0] sat_q;
    logic signed [16:0] dx_in, dy_in;

    always_comb
    begin
        dx_mag = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
        dy_mag = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];
        sq_sum = {17'd0, dx_mag} * {17'd0, dx_mag} + {17'd0, dy_mag} * {17'd0, dy_mag};

        // One bit-pair step of the restoring square root.
        s_rem2  = {srem_reg[RW-3:0], rad_reg[SRW-1:SRW-2]};
        s_trial = {root_reg, 2'b01};
        s_ge    = (s_rem2 >= s_trial);
        s_diff  = s_rem2 - s_trial;

        // One bit of the restoring divider.
        d_t    = {drem_reg, num_reg[NW-1]};
        d_ge   = (d_t >= {1'b0, den_reg});
        d_diff = d_t - {1'b0, den_reg};

        off_prod_y = half_width_reg * dy_mag;
        off_prod_x = half_width_reg * dx_mag;
        q13        = {1'b0, num_reg[11:0]};

        // Edge point and its forward distance to the camera.
        ex_w   = {{2{cur_x_reg[15]}}, cur_x_reg}
               + (side_reg ? -{{5{ox_reg[12]}}, ox_reg} : {{5{ox_reg[12]}}, ox_reg});
        ey_w   = {{2{cur_y_reg[15]}}, cur_y_reg}
               + (side_reg ? {{5{oy_reg[12]}}, oy_reg} : -{{5{oy_reg[12]}}, oy_reg});
        dist_w = ey_w + {6'd0, camera_back_reg};

        mul_a = (tgt_reg == DT_SX) ? ex_reg : {6'd0, camera_height_reg};
        mul_b = {1'b0, pixel_scale_reg};
        mul_c = (tgt_reg == DT_SX) ? {1'b0, center_x_reg} : {1'b0, center_y_reg};
        prod1 = mul_a * mul_b;
        prod2 = mul_c * dist_reg;

        pix_sum = p1_reg + p2_reg;
        pix_mag = pix_sum[31] ? 32'(-pix_sum) : pix_sum;

        // Saturate the signed quotient to 16 bits.
        if (neg_reg)
            sat_q = (num_reg > NW'(32768)) ? -16'sd32768 : 16'(-num_reg[15:0]);
        else
            sat_q = (num_reg > NW'(32767)) ? 16'sd32767 : num_reg[15:0];

        dx_in = {in_data.point_x[15], in_data.point_x} - {prev_x_reg[15], prev_x_reg};
        dy_in = {in_data.point_y[15], in_data.point_y} - {prev_y_reg[15], prev_y_reg};
    end

    always_comb
    begin
        state_next     = state_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        last_next      = last_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        num_next       = num_reg;
        drem_next      = drem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        tgt_next       = tgt_reg;
        cnt_next       = cnt_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        side_next      = side_reg;
        ex_next        = ex_reg;
        dist_next      = dist_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        sx_next        = sx_reg;
        behind_next    = behind_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cur_x_next  = in_data.point_x;
                    cur_y_next  = in_data.point_y;
                    last_next   = in_data.path_end;
                    prev_x_next = in_data.point_x;
                    prev_y_next = in_data.point_y;
                    dx_next     = dx_in;
                    dy_next     = dy_in;
                    side_next   = 1'b0;
                    if (in_data.path_start)
                    begin
                        // Straight ahead: full width sideways, no forward shift.
                        ox_next    = {1'b0, half_width_reg};
                        oy_next    = '0;
                        state_next = ST_EDGE;
                    end
                    else if (dx_in == '0 && dy_in == '0)
                    begin
                        // Repeated point takes heading angle zero.
                        ox_next    = '0;
                        oy_next    = {1'b0, half_width_reg};
                        state_next = ST_EDGE;
                    end
                    else
                    begin
                        state_next = ST_SQ;
                    end
                end
            end

            ST_SQ:
            begin
                rad_next   = {1'b0, sq_sum, {(2 * FRAC_BITS){1'b0}}};
                root_next  = '0;
                srem_next  = '0;
                cnt_next   = CW'(SI);
                state_next = ST_SQRT;
            end

            ST_SQRT:
            begin
                if (cnt_reg != '0)
                begin
                    srem_next = s_ge ? s_diff : s_rem2;
                    root_next = {root_reg[LW-2:0], s_ge};
                    rad_next  = {rad_reg[SRW-3:0], 2'b00};
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    // Length is final: start the sideways offset divide.
                    num_next   = {off_prod_y, {FRAC_BITS{1'b0}}};
                    den_next   = root_reg;
                    drem_next  = '0;
                    neg_next   = dy_reg[16];
                    tgt_next   = DT_OX;
                    cnt_next   = CW'(NW);
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    drem_next = d_ge ? d_diff[DW-1:0] : d_t[DW-1:0];
                    num_next  = {num_reg[NW-2:0], d_ge};
                    cnt_next  = cnt_reg - 1'b1;
                end
                else
                begin
                    case (tgt_reg)
                        DT_OX:
                        begin
                            ox_next   = neg_reg ? -q13 : q13;
                            num_next  = {off_prod_x, {FRAC_BITS{1'b0}}};
                            drem_next = '0;
                            neg_next  = dx_reg[16];
                            tgt_next  = DT_OY;
                            cnt_next  = CW'(NW);
                        end
                        DT_OY:
                        begin
                            oy_next    = neg_reg ? -q13 : q13;
                            state_next = ST_EDGE;
                        end
                        DT_SX:
                        begin
                            sx_next    = sat_q;
                            tgt_next   = DT_SY;
                            state_next = ST_MUL;
                        end
                        default:
                        begin
                            out_next.side          = side_reg;
                            out_next.screen_x      = sx_reg;
                            out_next.screen_y      = sat_q;
                            out_next.behind_camera = 1'b0;
                            out_next.pair_last     = side_reg;
                            out_next.path_last     = last_reg;
                            out_valid_next         = 1'b1;
                            state_next             = ST_OUT;
                        end
                    endcase
                end
            end

            ST_EDGE:
            begin
                ex_next     = ex_w;
                dist_next   = dist_w;
                behind_next = (dist_w <= 18'sd0);
                tgt_next    = DT_SX;
                if (dist_w <= 18'sd0)
                begin
                    out_next.side          = side_reg;
                    out_next.screen_x      = '0;
                    out_next.screen_y      = '0;
                    out_next.behind_camera = 1'b1;
                    out_next.pair_last     = side_reg;
                    out_next.path_last     = last_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_OUT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                p1_next    = {prod1[30], prod1};
                p2_next    = {prod2[30], prod2};
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                num_next   = NW'(pix_mag);
                neg_next   = pix_sum[31] && !behind_reg;
                den_next   = DW'(dist_reg[16:0]);
                drem_next  = '0;
                cnt_next   = CW'(NW);
                state_next = ST_DIV;
            end

            ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (side_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        side_next  = 1'b1;
                        state_next = ST_EDGE;
                    end
                end
            end

            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        last_reg   <= last_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        srem_reg   <= srem_next;
        num_reg    <= num_next;
        drem_reg   <= drem_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        tgt_reg    <= tgt_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        side_reg   <= side_next;
        ex_reg     <= ex_next;
        dist_reg   <= dist_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        sx_reg     <= sx_next;
        behind_reg <= behind_next;
        out_reg    <= out_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- tb/tb_path_corridor_perspective_projector_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path corridor projector testbench
// Streams path points into the core under random idling on both channels.
// An internal model predicts the right and left edge beats of every point,
// and a scoreboard compares each output beat and reports a mismatch field by field.
// ----------------------------------------------------------------------------
module tb_path_corridor_perspective_projector_core;

    import pcpp_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    // Collects the predicted edge beats and checks the core's output against them.
    class edge_scoreboard;
        out_t edge_q[$];
        int   mismatches;
        int   beats_checked;

        function void note_point(input out_t right_beat, input out_t left_beat);
            edge_q.push_back(right_beat);
            edge_q.push_back(left_beat);
        endfunction

        function void check_beat(input out_t got);
            out_t want;
            if (edge_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output beat %h", got);
                return;
            end
            want = edge_q.pop_front();
            beats_checked++;
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: beat %0d side exp %0d got %0d, sx exp %0d got %0d,",
                              " sy exp %0d got %0d, behind exp %0d got %0d,",
                              " pair exp %0d got %0d, last exp %0d got %0d"},
                        beats_checked, want.side, got.side, want.screen_x, got.screen_x,
                        want.screen_y, got.screen_y, want.behind_camera, got.behind_camera,
                        want.pair_last, got.pair_last, want.path_last, got.path_last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    path_corridor_perspective_projector_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model copy of the registers and the previous point.
    longint half_width_m, camera_back_m, camera_height_m;
    longint pixel_scale_m, center_x_m, center_y_m;
    longint prev_x_m, prev_y_m;

    edge_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  points_sent;
    int  paths_sent;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit: a watchdog ends the run as a failure should the points, slowed by
    // heavy output stalls, not all have gone through in time.
    initial
    begin
        #(4 * 2_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint isqrt_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v -= r + bitv;
                r = (r >> 1) + bitv;
            end
            else
            begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Half width times a direction component over the length, toward zero.
    function automatic longint edge_offset(input longint d, input longint len);
        longint q;
        q = ((half_width_m * mag(d)) << FB) / len;
        return (d < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // Pinhole projection of one edge point; SV division truncates toward zero.
    function automatic out_t project_edge(input longint ex, input longint ey,
                                          input logic side, input logic last);
        out_t   b;
        longint depth;
        depth = ey + camera_back_m;
        b = '0;
        b.side = side;
        b.pair_last = side;
        b.path_last = last;
        if (depth <= 0)
        begin
            b.behind_camera = 1'b1;
        end
        else
        begin
            b.screen_x = clamp16((ex * pixel_scale_m + center_x_m * depth) / depth);
            b.screen_y = clamp16((camera_height_m * pixel_scale_m + center_y_m * depth)
                                 / depth);
        end
        return b;
    endfunction

    function automatic void predict_edges(input in_t p);
        longint x, y, dx, dy, ox, oy, len;
        x = longint'(p.point_x);
        y = longint'(p.point_y);
        if (p.path_start)
        begin
            ox = half_width_m;
            oy = 0;
        end
        else
        begin
            dx = x - prev_x_m;
            dy = y - prev_y_m;
            if (dx == 0 && dy == 0)
            begin
                ox = 0;
                oy = half_width_m;
            end
            else
            begin
                len = isqrt_floor(longint'(dx * dx + dy * dy) << (2 * FB));
                if (len == 0) len = 1;
                ox = edge_offset(dy, len);
                oy = edge_offset(dx, len);
            end
        end
        prev_x_m = x;
        prev_y_m = y;
        sb.note_point(project_edge(x + ox, y - oy, 1'b0, p.path_end),
                      project_edge(x - ox, y + oy, 1'b1, p.path_end));
    endfunction

    // Output side: random stall, sample at the rising edge.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_beat(out_data);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_HALF_WIDTH:    half_width_m    = longint'(value);
            REG_CAMERA_BACK:   camera_back_m   = longint'(value);
            REG_CAMERA_HEIGHT: camera_height_m = longint'(value);
            REG_PIXEL_SCALE:   pixel_scale_m   = longint'(value);
            REG_CENTER_X:      center_x_m      = longint'(value);
            REG_CENTER_Y:      center_y_m      = longint'(value);
            default: ;
        endcase
    endtask

    task automatic load_settings(input int hw, input int cb, input int ch,
                                 input int ps, input int cx, input int cy);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_CAMERA_BACK, cb);
        write_reg(REG_CAMERA_HEIGHT, ch);
        write_reg(REG_PIXEL_SCALE, ps);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
    endtask

    // Sends one point. Valid stays high from one beat into the next unless an
    // idle cycle is drawn, so it is never dropped and raised in one step.
    task automatic send_point(input logic signed [15:0] px, input logic signed [15:0] py,
                              input logic st, input logic en);
        in_t p;
        p.point_x = px;
        p.point_y = py;
        p.path_start = st;
        p.path_end = en;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_edges(p);
        points_sent++;
        if (en) paths_sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (sb.edge_q.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // A well-formed path: a start point, then small forward steps with jitter.
    task automatic send_path(input int npts);
        int x, y;
        x = $urandom_range(4000) - 2000;
        y = $urandom_range(2000) - 200;
        for (int i = 0; i < npts; i++)
        begin
            send_point(16'(x), 16'(y), i == 0, i == npts - 1);
            x = x + int'($urandom_range(200)) - 100;
            y = y + int'($urandom_range(300)) - 60;
        end
    endtask

    task automatic random_phase(input int npts);
        int n;
        int plen;
        n = 0;
        while (n < npts)
        begin
            if ($urandom_range(9) < 8)
            begin
                plen = int'($urandom_range(40, 3));
                send_path(plen);
                n += plen;
            end
            else
            begin
                send_point(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
                n++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 29;
        recv_idle_pct = 77;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        half_width_m = longint'(HALF_WIDTH_RST);
        camera_back_m = longint'(CAMERA_BACK_RST);
        camera_height_m = longint'(CAMERA_HEIGHT_RST);
        pixel_scale_m = longint'(PIXEL_SCALE_RST);
        center_x_m = longint'(CENTER_X_RST);
        center_y_m = longint'(CENTER_Y_RST);
        prev_x_m = 0;
        prev_y_m = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: first point without a start uses the origin as the previous
        // point, then a repeat, a path start, field extremes and behind-camera.
        send_point(16'sd100, 16'sd500, 1'b0, 1'b0);
        send_point(16'sd100, 16'sd500, 1'b0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0, 1'b0);
        send_point(-16'sd32768, -16'sd32768, 1'b0, 1'b1);
        send_point(-16'sd32768, 16'sd32767, 1'b1, 1'b1);
        send_point(16'sd0, -16'sd51, 1'b1, 1'b0);
        send_point(16'sd0, -16'sd2000, 1'b0, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0, 1'b1);
        send_point(-16'sd1, 16'sd0, 1'b0, 1'b0);
        send_point(16'sd32767, -16'sd32768, 1'b0, 1'b0);
        drain();

        // Extreme settings: high register values, then values of zero or one.
        load_settings(2560, 2560, 2560, 4095, 4095, 4095);
        send_point(16'sd32767, 16'sd0, 1'b1, 1'b0);
        send_point(-16'sd32768, 16'sd32767, 1'b0, 1'b0);
        send_point(16'sd0, -16'sd32768, 1'b0, 1'b1);
        drain();
        load_settings(0, 1, 0, 1, 0, 0);
        send_point(16'sd5, -16'sd1, 1'b1, 1'b0);
        send_point(16'sd300, 16'sd9000, 1'b0, 1'b0);
        send_point(16'sd300, 16'sd9000, 1'b0, 1'b1);
        drain();

        load_settings(282, 51, 256, 200, 280, 210);
        random_phase(330);
        drain();

        send_idle_pct = 77;
        recv_idle_pct = 29;
        load_settings(int'($urandom_range(2560)), int'($urandom_range(2560, 1)),
                      int'($urandom_range(2560)), int'($urandom_range(4095, 1)),
                      int'($urandom_range(4095)), int'($urandom_range(4095)));
        random_phase(330);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(int'($urandom_range(600)), int'($urandom_range(400, 1)),
                      int'($urandom_range(800)), int'($urandom_range(600, 1)),
                      int'($urandom_range(640)), int'($urandom_range(480)));
        random_phase(360);
        drain();

        $display("Covered %0d points in %0d ended paths, %0d edge beats checked.",
                 points_sent, paths_sent, sb.beats_checked);
        $display("Settings ran at reset, both extremes and two random sets.");
        if (sb.mismatches == 0 && sb.edge_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
src/pcpp_pkg.sv
src/path_corridor_perspective_projector_core.sv
tb/tb_path_corridor_perspective_projector_core.sv
